[rtl/sha1_stream_hasher_core_defines.svh]
// Assertion macros for the SHA-1 stream hasher.
`ifndef SHA1_STREAM_HASHER_CORE_DEFINES_SVH
`define SHA1_STREAM_HASHER_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SHA1SH_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define SHA1SH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/sha1sh_pkg.sv]
// Package: SHA-1 constants, register indexes and round helpers.
package sha1sh_pkg;

  localparam int unsigned NumWords = 5;
  localparam int unsigned SbcW     = 55;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned RndW     = 7;

  typedef logic [31:0] word_t;
  typedef logic [15:0][31:0] win_t;

  localparam logic [CfgIdxW-1:0] CFG_H0  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_SBC = 3'd5;

  localparam word_t IV0 = 32'h6745_2301;
  localparam word_t IV1 = 32'hEFCD_AB89;
  localparam word_t IV2 = 32'h98BA_DCFE;
  localparam word_t IV3 = 32'h1032_5476;
  localparam word_t IV4 = 32'hC3D2_E1F0;

  localparam word_t K0 = 32'h5A82_7999;
  localparam word_t K1 = 32'h6ED9_EBA1;
  localparam word_t K2 = 32'h8F1B_BCDC;
  localparam word_t K3 = 32'hCA62_C1D6;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  function automatic word_t rol(word_t x, int unsigned n);
    word_t r;
    r = (x << n) | (x >> (32 - n));
    return r;
  endfunction

  function automatic word_t round_f(logic [RndW-1:0] rnd, word_t b, word_t c, word_t d);
    word_t f;
    if (rnd < 7'd20) begin
      f = (b & c) | (~b & d);
    end else if (rnd < 7'd40) begin
      f = b ^ c ^ d;
    end else if (rnd < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
    end else begin
      f = b ^ c ^ d;
    end
    return f;
  endfunction

  function automatic word_t round_k(logic [RndW-1:0] rnd);
    word_t k;
    if (rnd < 7'd20) begin
      k = K0;
    end else if (rnd < 7'd40) begin
      k = K1;
    end else if (rnd < 7'd60) begin
      k = K2;
    end else begin
      k = K3;
    end
    return k;
  endfunction

endpackage

[rtl/sha1_stream_hasher_core.sv]
// SHA-1 stream hasher: byte intake, padding sequencer, one round per cycle, digest out.
//
// Channel   Dir  tdata                   tuser            tlast
// s_axis    in   [7:0] message_byte      [0] has_byte     end_of_message
// m_axis    out  [31:0] digest_word      [2:0] word_index last_word
// cfg       in   cfg_idx_i selects register, cfg_data_i[54:0] value, cfg_we_i writes
//
// The byte that fills a 64-byte block starts 80 rounds through the single round unit,
// followed by one chaining add; no byte is taken until they are done.
// The closing transfer adds padding bytes, one or two blocks and 5 digest transfers.
// s_axis_tready_o is high only while the core waits for input.
// Reset clears control state and loads the standard initial words into the configuration registers.
// A stalled m_axis holds the current digest word.
module sha1_stream_hasher_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] message_byte
  input  logic        s_axis_tuser_i,   // [0] has_byte
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [31:0] digest_word
  output logic [2:0]  m_axis_tuser_o,   // [2:0] word_index
  output logic        m_axis_tlast_o,
  input  logic        cfg_we_i,
  input  logic [sha1sh_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [sha1sh_pkg::SbcW-1:0]    cfg_data_i
);

  `include "sha1_stream_hasher_core_defines.svh"

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PAD   = 3'd1;
  localparam logic [2:0] ST_ROUND = 3'd2;
  localparam logic [2:0] ST_FINAL = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  localparam logic [5:0] POS_LEN  = 6'd56;
  localparam logic [5:0] POS_LAST = 6'd63;
  localparam logic [6:0] RND_LAST = 7'd79;
  localparam logic [2:0] IDX_LAST = 3'd4;

  logic [2:0] state_q, state_d, ret_q, ret_d;
  logic       in_msg_q, in_msg_d;
  logic       pad_first_q, pad_first_d;
  logic       len_mode_q, len_mode_d;
  logic [sha1sh_pkg::RndW-1:0] rnd_q, rnd_d;
  logic [2:0] oidx_q, oidx_d;
  logic [63:0] len_q, len_d, len_sh_q, len_sh_d, base_len;

  sha1sh_pkg::word_t cfg_h_q [sha1sh_pkg::NumWords];
  logic [sha1sh_pkg::SbcW-1:0] cfg_sbc_q;

  sha1sh_pkg::word_t chain_q [sha1sh_pkg::NumWords];
  sha1sh_pkg::word_t chain_d [sha1sh_pkg::NumWords];
  sha1sh_pkg::word_t work_q  [sha1sh_pkg::NumWords];
  sha1sh_pkg::word_t work_d  [sha1sh_pkg::NumWords];
  sha1sh_pkg::win_t  win_q, win_d;

  logic       push_en, push_len;
  logic [7:0] push_byte;
  logic [5:0] pos;
  sha1sh_pkg::word_t tmp, new_w;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_h_q[0] <= sha1sh_pkg::IV0;
      cfg_h_q[1] <= sha1sh_pkg::IV1;
      cfg_h_q[2] <= sha1sh_pkg::IV2;
      cfg_h_q[3] <= sha1sh_pkg::IV3;
      cfg_h_q[4] <= sha1sh_pkg::IV4;
      cfg_sbc_q  <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i < sha1sh_pkg::CFG_SBC) begin
        cfg_h_q[cfg_idx_i] <= cfg_data_i[31:0];
      end else if (cfg_idx_i == sha1sh_pkg::CFG_SBC) begin
        cfg_sbc_q <= cfg_data_i;
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    ret_d       = ret_q;
    in_msg_d    = in_msg_q;
    pad_first_d = pad_first_q;
    len_mode_d  = len_mode_q;
    rnd_d       = rnd_q;
    oidx_d      = oidx_q;
    len_sh_d    = len_sh_q;
    chain_d     = chain_q;
    work_d      = work_q;
    win_d       = win_q;
    base_len    = len_q;
    push_en     = 1'b0;
    push_len    = 1'b0;
    push_byte   = '0;
    tmp         = '0;
    new_w       = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          if (!in_msg_q) begin
            chain_d  = cfg_h_q;
            base_len = {cfg_sbc_q, 9'd0};
            in_msg_d = 1'b1;
          end
          push_en   = s_axis_tuser_i;
          push_byte = s_axis_tdata_i;
          if (s_axis_tlast_i) begin
            pad_first_d = 1'b1;
            len_mode_d  = 1'b0;
            len_sh_d    = base_len + (push_en ? 64'd8 : 64'd0);
            state_d     = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        push_en = 1'b1;
        if (pad_first_q) begin
          push_byte   = sha1sh_pkg::PAD_BYTE;
          pad_first_d = 1'b0;
        end else if (len_mode_q || (len_q[8:3] == POS_LEN)) begin
          push_byte  = len_sh_q[63:56];
          len_sh_d   = len_sh_q << 8;
          len_mode_d = 1'b1;
          push_len   = 1'b1;
        end
      end
      ST_ROUND: begin
        tmp = sha1sh_pkg::rol(work_q[0], 5)
            + sha1sh_pkg::round_f(rnd_q, work_q[1], work_q[2], work_q[3])
            + work_q[4] + win_q[15] + sha1sh_pkg::round_k(rnd_q);
        new_w = sha1sh_pkg::rol(win_q[2] ^ win_q[7] ^ win_q[13] ^ win_q[15], 1);
        work_d[4] = work_q[3];
        work_d[3] = work_q[2];
        work_d[2] = sha1sh_pkg::rol(work_q[1], 30);
        work_d[1] = work_q[0];
        work_d[0] = tmp;
        win_d     = {win_q[14:0], new_w};
        rnd_d     = rnd_q + 7'd1;
        if (rnd_q == RND_LAST) begin
          state_d = ST_FINAL;
        end
      end
      ST_FINAL: begin
        for (int i = 0; i < sha1sh_pkg::NumWords; i++) begin
          chain_d[i] = chain_q[i] + work_q[i];
        end
        state_d = ret_q;
      end
      ST_OUT: begin
        if (m_axis_tready_i) begin
          if (oidx_q == IDX_LAST) begin
            oidx_d   = '0;
            in_msg_d = 1'b0;
            state_d  = ST_IDLE;
          end else begin
            oidx_d = oidx_q + 3'd1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // shared byte intake: shift into the window, advance the length, start a block
    pos   = base_len[8:3];
    len_d = base_len;
    if (push_en) begin
      win_d = {win_q[15][23:0], win_q[14:0], push_byte};
      len_d = base_len + 64'd8;
      if (pos == POS_LAST) begin
        work_d  = chain_q;
        rnd_d   = '0;
        ret_d   = push_len ? ST_OUT : state_d;
        state_d = ST_ROUND;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ret_q       <= ST_IDLE;
      in_msg_q    <= 1'b0;
      pad_first_q <= 1'b0;
      len_mode_q  <= 1'b0;
      rnd_q       <= '0;
      oidx_q      <= '0;
      len_q       <= '0;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      in_msg_q    <= in_msg_d;
      pad_first_q <= pad_first_d;
      len_mode_q  <= len_mode_d;
      rnd_q       <= rnd_d;
      oidx_q      <= oidx_d;
      len_q       <= len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    len_sh_q <= len_sh_d;
    chain_q  <= chain_d;
    work_q   <= work_d;
    win_q    <= win_d;
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = (state_q == ST_OUT);
  assign m_axis_tdata_o  = chain_q[oidx_q];
  assign m_axis_tuser_o  = oidx_q;
  assign m_axis_tlast_o  = (oidx_q == IDX_LAST);

  `SHA1SH_ASSERT_NOW(a_no_overlap, s_axis_tready_o, !m_axis_tvalid_o, "input and output overlap")
  `SHA1SH_ASSERT_NOW(a_round_range, state_q == ST_ROUND, rnd_q <= RND_LAST, "round count out of range")
  `SHA1SH_ASSERT_NOW(a_block_aligned, (state_q == ST_ROUND) && (rnd_q == '0), len_q[8:3] == '0,
                     "block started off a block boundary")
  `SHA1SH_ASSERT_NEXT(a_back_to_idle, m_axis_tvalid_o && m_axis_tready_i && m_axis_tlast_o,
                      s_axis_tready_o && !in_msg_q, "core not idle after digest")

endmodule
